/* hdl/conv3_pkg.sv */
package conv3_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int PIXEL_BITS_DEF = 16;

    // kernel words are signed Q4.12
    localparam int COEF_W     = 16;
    localparam int FRAC_SHIFT = 12;
    // headroom for the sum of nine products
    localparam int SUM_GUARD  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIM_REG_W  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM  = 3'd4;

    localparam logic [DIM_REG_W-1:0]  DIM_RESET        = 7'd64;
    // -0.125 around a centre of 2.0
    localparam logic [CFG_DATA_W-1:0] COEF_EDGE_RESET  = 48'hFE00_FE00_FE00;
    localparam logic [CFG_DATA_W-1:0] COEF_MID_RESET   = 48'hFE00_2000_FE00;

    // input actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // kernel taps, raster order over the 3x3 window
    localparam int TAP_W = 4;
    localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;

    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
    } t_mac_ctrl;

    function automatic logic [COEF_W-1:0] coef_sel(
        input logic [CFG_DATA_W-1:0] top,
        input logic [CFG_DATA_W-1:0] mid,
        input logic [CFG_DATA_W-1:0] bot,
        input logic [TAP_W-1:0]      tap
    );
        logic [COEF_W-1:0] w;
        w = '0;
        unique case (tap)
            4'd0:    w = top[15:0];
            4'd1:    w = top[31:16];
            4'd2:    w = top[47:32];
            4'd3:    w = mid[15:0];
            4'd4:    w = mid[31:16];
            4'd5:    w = mid[47:32];
            4'd6:    w = bot[15:0];
            4'd7:    w = bot[31:16];
            4'd8:    w = bot[47:32];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

/* hdl/conv3_mac.sv */
module conv3_mac #(
    parameter int PIXEL_BITS = conv3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  conv3_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    input  logic signed [conv3_pkg::COEF_W-1:0]  i_coef,
    output logic signed [PIXEL_BITS+conv3_pkg::COEF_W+conv3_pkg::SUM_GUARD-1:0] o_acc,
    output logic                                 o_done
);

    localparam int PROD_W = PIXEL_BITS + conv3_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + conv3_pkg::SUM_GUARD;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvld;
    logic                     r_plast;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    // multiply stage, registered before the add
    always_ff @(posedge i_clk) begin
        r_prod <= i_pixel * i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld  <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pvld  <= i_ctrl.vld;
            r_plast <= i_ctrl.last;
            r_done  <= r_pvld && r_plast;
        end
    end

    // accumulate stage, exact sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

/* hdl/conv3x3_clamped_frame_filter.sv */
// channel  | direction | signals                               | accepted when
// ---------+-----------+---------------------------------------+--------------------------
// command  | in        | i_action, i_pixel_in                  | start high, busy low
// result   | out       | o_pixel_out, o_frame_last             | o_strobe high, one cycle
// config   | in        | i_cfg_idx, i_cfg_wdata                | i_cfg_we high
//
// a load beat never raises busy
// a border fetch goes through ST_FIN and the result register, with the stored pixel as its result
// an interior fetch holds busy while nine window reads go one per cycle through
// the single read port of the frame memory and one shared multiply-accumulate unit
// reset is synchronous and active low; the frame memory is not cleared
// results go out for one cycle on o_strobe and cannot be held off
module conv3x3_clamped_frame_filter #(
    parameter int MAX_WIDTH  = conv3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = conv3_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = conv3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_action,
    input  logic signed [PIXEL_BITS-1:0]        i_pixel_in,
    output logic                                o_strobe,
    output logic signed [PIXEL_BITS-1:0]        o_pixel_out,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int ACC_W  = PIXEL_BITS + conv3_pkg::COEF_W + conv3_pkg::SUM_GUARD;
    localparam int SH_W   = ACC_W - conv3_pkg::FRAC_SHIFT;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    // configuration registers
    logic [conv3_pkg::DIM_REG_W-1:0]  r_cfg_width;
    logic [conv3_pkg::DIM_REG_W-1:0]  r_cfg_height;
    logic [conv3_pkg::CFG_DATA_W-1:0] r_coef_top;
    logic [conv3_pkg::CFG_DATA_W-1:0] r_coef_mid;
    logic [conv3_pkg::CFG_DATA_W-1:0] r_coef_bot;

    // frame memory, contents undefined until loaded
    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_mem_q;
    logic [ADDR_W-1:0]     rd_addr;

    // load side
    logic [ADDR_W-1:0]     r_laddr;
    logic [W_BITS-1:0]     r_lcol;
    logic [H_BITS-1:0]     r_lrow;
    logic                  r_full;
    logic signed [PIXEL_BITS-1:0] r_min;
    logic signed [PIXEL_BITS-1:0] r_max;

    // emit side
    logic [ADDR_W-1:0]     r_eaddr;
    logic [W_BITS-1:0]     r_ecol;
    logic [H_BITS-1:0]     r_erow;

    // sequencer
    logic [1:0]                    r_state;
    logic                          r_iss;
    logic [conv3_pkg::TAP_W-1:0]   r_tap;
    logic [1:0]                    r_dc;
    logic [ADDR_W-1:0]             r_tap_addr;
    logic                          r_d1_vld;
    logic [conv3_pkg::TAP_W-1:0]   r_d1_tap;

    logic                          r_strobe;
    logic signed [PIXEL_BITS-1:0]  r_pixel_out;
    logic                          r_frame_last;

    logic [W_BITS-1:0] w_eff;
    logic [H_BITS-1:0] h_eff;
    logic              acc_beat;
    logic              load_go;
    logic              fetch_go;
    logic              on_border;
    logic              fin_go;
    logic              last_pix;
    logic              restart;
    logic signed [PIXEL_BITS-1:0] pix_val;

    conv3_pkg::t_mac_ctrl                  mac_ctrl;
    logic signed [ACC_W-1:0]               mac_acc;
    logic                                  mac_done;
    logic signed [SH_W-1:0]                sh_val;
    logic signed [SH_W-1:0]                min_x;
    logic signed [SH_W-1:0]                max_x;
    logic signed [SH_W-1:0]                clamp_val;

    // effective frame size: zero reads as one, oversize as the maximum
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = W_BITS'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = W_BITS'(MAX_WIDTH);
        end else begin
            w_eff = W_BITS'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = H_BITS'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = H_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = H_BITS'(r_cfg_height);
        end
    end

    assign busy      = (r_state != ST_IDLE);
    assign acc_beat  = start && !busy;
    assign load_go   = acc_beat && (i_action == conv3_pkg::ACT_LOAD) && !r_full;
    // fetches before the frame is complete fall through with no result
    assign fetch_go  = acc_beat && (i_action == conv3_pkg::ACT_FETCH) && r_full;
    assign on_border = (r_erow == '0) || (r_ecol == '0) ||
                       (r_erow == h_eff - H_BITS'(1)) || (r_ecol == w_eff - W_BITS'(1));
    assign last_pix  = (r_erow == h_eff - H_BITS'(1)) && (r_ecol == w_eff - W_BITS'(1));
    assign fin_go    = (r_state == ST_FIN) || ((r_state == ST_MAC) && mac_done);
    assign restart   = (i_cfg_we && (i_cfg_idx == conv3_pkg::CFG_FRAME_WIDTH ||
                                     i_cfg_idx == conv3_pkg::CFG_FRAME_HEIGHT))
                       || (fin_go && last_pix);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= conv3_pkg::DIM_RESET;
            r_cfg_height <= conv3_pkg::DIM_RESET;
            r_coef_top   <= conv3_pkg::COEF_EDGE_RESET;
            r_coef_mid   <= conv3_pkg::COEF_MID_RESET;
            r_coef_bot   <= conv3_pkg::COEF_EDGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                conv3_pkg::CFG_FRAME_WIDTH:
                    r_cfg_width  <= i_cfg_wdata[conv3_pkg::DIM_REG_W-1:0];
                conv3_pkg::CFG_FRAME_HEIGHT:
                    r_cfg_height <= i_cfg_wdata[conv3_pkg::DIM_REG_W-1:0];
                conv3_pkg::CFG_COEF_TOP:    r_coef_top <= i_cfg_wdata;
                conv3_pkg::CFG_COEF_MIDDLE: r_coef_mid <= i_cfg_wdata;
                conv3_pkg::CFG_COEF_BOTTOM: r_coef_bot <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame memory: one write port for loads, one registered read port
    assign rd_addr = (r_state == ST_MAC) ? r_tap_addr : r_eaddr;

    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_mem[r_laddr] <= i_pixel_in;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // frame counters and running min/max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_laddr <= '0;
            r_lcol  <= '0;
            r_lrow  <= '0;
            r_full  <= 1'b0;
            r_min   <= PIX_MAX;
            r_max   <= PIX_MIN;
            r_eaddr <= '0;
            r_ecol  <= '0;
            r_erow  <= '0;
        end else begin
            if (load_go) begin
                r_laddr <= r_laddr + ADDR_W'(1);
                if (i_pixel_in < r_min) begin
                    r_min <= i_pixel_in;
                end
                if (i_pixel_in > r_max) begin
                    r_max <= i_pixel_in;
                end
                if (r_lcol == w_eff - W_BITS'(1)) begin
                    r_lcol <= '0;
                    if (r_lrow == h_eff - H_BITS'(1)) begin
                        r_full <= 1'b1;
                    end else begin
                        r_lrow <= r_lrow + H_BITS'(1);
                    end
                end else begin
                    r_lcol <= r_lcol + W_BITS'(1);
                end
            end
            if (fin_go) begin
                r_eaddr <= r_eaddr + ADDR_W'(1);
                if (r_ecol == w_eff - W_BITS'(1)) begin
                    r_ecol <= '0;
                    r_erow <= r_erow + H_BITS'(1);
                end else begin
                    r_ecol <= r_ecol + W_BITS'(1);
                end
            end
        end
    end

    // sequencer: walk the 3x3 window one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_iss    <= 1'b0;
            r_d1_vld <= 1'b0;
        end else begin
            r_d1_vld <= (r_state == ST_MAC) && r_iss;
            unique case (r_state)
                ST_IDLE: begin
                    if (fetch_go) begin
                        // the border pixel is already on the read port
                        r_state <= on_border ? ST_FIN : ST_MAC;
                        r_iss   <= !on_border;
                    end
                end
                ST_MAC: begin
                    if (r_iss && (r_tap == conv3_pkg::TAP_LAST)) begin
                        r_iss <= 1'b0;
                    end
                    if (mac_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // window address walk, top-left neighbour first
    always_ff @(posedge i_clk) begin
        if (fetch_go) begin
            r_tap      <= '0;
            r_dc       <= '0;
            r_tap_addr <= r_eaddr - ADDR_W'(w_eff) - ADDR_W'(1);
        end else if ((r_state == ST_MAC) && r_iss) begin
            r_tap <= r_tap + conv3_pkg::TAP_W'(1);
            if (r_dc == 2'd2) begin
                r_dc       <= '0;
                r_tap_addr <= r_tap_addr + ADDR_W'(w_eff) - ADDR_W'(2);
            end else begin
                r_dc       <= r_dc + 2'd1;
                r_tap_addr <= r_tap_addr + ADDR_W'(1);
            end
        end
        r_d1_tap <= r_tap;
    end

    assign mac_ctrl.clr  = fetch_go;
    assign mac_ctrl.vld  = r_d1_vld;
    assign mac_ctrl.last = (r_d1_tap == conv3_pkg::TAP_LAST);

    conv3_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_pixel (r_mem_q),
        .i_coef  (conv3_pkg::coef_sel(r_coef_top, r_coef_mid, r_coef_bot, r_d1_tap)),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // back to Q8.8 by arithmetic shift, then clamp to the frame's own range
    always_comb begin
        sh_val = mac_acc[ACC_W-1:conv3_pkg::FRAC_SHIFT];
        min_x  = {{(SH_W-PIXEL_BITS){r_min[PIXEL_BITS-1]}}, r_min};
        max_x  = {{(SH_W-PIXEL_BITS){r_max[PIXEL_BITS-1]}}, r_max};
        if (sh_val < min_x) begin
            clamp_val = min_x;
        end else if (sh_val > max_x) begin
            clamp_val = max_x;
        end else begin
            clamp_val = sh_val;
        end
        pix_val = (r_state == ST_FIN) ? r_mem_q : clamp_val[PIXEL_BITS-1:0];
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_frame_last <= 1'b0;
        end else begin
            r_strobe     <= fin_go;
            r_frame_last <= fin_go && last_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_pixel_out <= pix_val;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

endmodule

/* hdl/conv3_chk.sv */
module conv3_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_action,
    input logic o_strobe,
    input logic o_frame_last
);

    // a result beat lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // a result only follows a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a preceding fetch");

    // loads never produce a result next cycle
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_action) |=> !o_strobe)
        else $error("load beat produced a result");

    // end-of-frame marker only rides on a result beat
    a_last_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_last |-> o_strobe)
        else $error("frame_last without a result beat");

endmodule

bind conv3x3_clamped_frame_filter conv3_chk u_conv3_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_strobe     (o_strobe),
    .o_frame_last (o_frame_last)
);
